// File: hdl/ffba_pkg.sv
// Shared constants, types and command/status bundles for the first-fit block allocator.
package ffba_pkg;

   localparam int POOL_BYTES   = 65536;
   localparam int HEADER_BYTES = 24;
   localparam int ALIGN_BYTES  = 8;
   localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);

   localparam int AMOUNT_W = 17;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;

   // One header slot per aligned offset of the pool.
   localparam int DEPTH  = POOL_BYTES / ALIGN_BYTES;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int POS_W  = $clog2(POOL_BYTES + 1);
   localparam int NEED_W = $clog2((2 ** AMOUNT_W) + HEADER_BYTES + 1);
   localparam int CMP_W  = (NEED_W > POS_W) ? NEED_W : POS_W;
   localparam int HIT_W  = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_ZERO     = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic             free;
      logic [POS_W-1:0] size;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_WAIT,
      S_EXAM,
      S_SPLIT,
      S_NWAIT,
      S_MERGE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       init_wr;
      logic       load;
      logic       advance;
      logic       take;
      logic       split_wr;
      logic       hit_latch;
      logic       merge_wr;
      logic       set_status;
      status_type status_code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic zero_req;
      logic null_free;
      logic fit;
      logic do_split;
      logic hit_free;
      logic at_end;
   } stat_type;

endpackage

// File: hdl/ffba_dp.sv
// Datapath: request registers, header memory, block walk pointers and merge/split arithmetic.
module ffba_dp (
   input  logic                            clock,
   input  ffba_pkg::cmd_type               cmd,
   input  logic                            req_action,
   input  logic [ffba_pkg::AMOUNT_W-1:0]   req_amount,
   input  logic [ffba_pkg::ADDR_W-1:0]     req_address,
   output ffba_pkg::stat_type              stat,
   output logic [ffba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]     rsp_granted_address
);
   import ffba_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   logic              action_ff;
   logic              zero_ff;
   logic [NEED_W-1:0] need_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [POS_W-1:0]  cur_start_ff;
   logic [POS_W-1:0]  prev_start_ff;
   logic [POS_W-1:0]  prev_size_ff;
   logic              prev_free_ff;
   logic [POS_W-1:0]  hit_start_ff;
   logic [POS_W-1:0]  hit_size_ff;
   logic              hit_end_ff;
   logic [POS_W-1:0]  extra_ff;
   status_type        status_ff;
   logic [ADDR_W-1:0] granted_ff;

   logic [NEED_W-1:0] round_amt;
   logic [NEED_W-1:0] need_in;
   logic [CMP_W-1:0]  size_ext;
   logic [CMP_W-1:0]  need_ext;
   logic [POS_W-1:0]  extra;
   logic [POS_W:0]    next_pos;
   logic [HIT_W-1:0]  payload_pos;
   logic [POS_W-1:0]  take_size;
   logic [POS_W-1:0]  split_pos;
   logic [POS_W-1:0]  base_start;
   logic [POS_W-1:0]  merge_size;
   logic              next_ok;
   logic              we;
   logic [POS_W-1:0]  wpos;
   entry_type         wdata;

   function automatic logic [IDX_W-1:0] slot(input logic [POS_W-1:0] pos);
      slot = pos[IDX_W+ALIGN_SHIFT-1:ALIGN_SHIFT];
   endfunction

   // Round the request up to the alignment and add room for the header.
   assign round_amt = (NEED_W'(req_amount) + NEED_W'(ALIGN_BYTES - 1))
                      & ~NEED_W'(ALIGN_BYTES - 1);
   assign need_in   = round_amt + NEED_W'(HEADER_BYTES);

   assign size_ext    = CMP_W'(rdata_ff.size);
   assign need_ext    = CMP_W'(need_ff);
   assign extra       = POS_W'(size_ext - need_ext);
   assign next_pos    = {1'b0, cur_start_ff} + {1'b0, rdata_ff.size};
   assign payload_pos = HIT_W'(cur_start_ff) + HIT_W'(HEADER_BYTES);
   assign take_size   = stat.do_split ? POS_W'(need_ff) : rdata_ff.size;
   assign split_pos   = cur_start_ff + POS_W'(need_ff);

   // Coalesce with the left neighbor and the right neighbor when they are free.
   assign next_ok    = !hit_end_ff && rdata_ff.free;
   assign base_start = prev_free_ff ? prev_start_ff : hit_start_ff;
   assign merge_size = (prev_free_ff ? prev_size_ff : '0) + hit_size_ff
                       + (next_ok ? rdata_ff.size : '0);

   assign stat.is_free   = (action_ff == ACT_FREE);
   assign stat.zero_req  = zero_ff;
   assign stat.null_free = (address_ff == '0);
   assign stat.fit       = rdata_ff.free && (size_ext >= need_ext);
   assign stat.do_split  = extra > POS_W'(HEADER_BYTES + ALIGN_BYTES);
   assign stat.hit_free  = (payload_pos == HIT_W'(address_ff));
   assign stat.at_end    = (next_pos >= (POS_W + 1)'(POOL_BYTES));

   always_comb begin
      we    = 1'b0;
      wpos  = cur_start_ff;
      wdata = rdata_ff;
      if (cmd.init_wr) begin
         we         = 1'b1;
         wpos       = '0;
         wdata.free = 1'b1;
         wdata.size = POS_W'(POOL_BYTES);
      end else if (cmd.take) begin
         we         = 1'b1;
         wpos       = cur_start_ff;
         wdata.free = 1'b0;
         wdata.size = take_size;
      end else if (cmd.split_wr) begin
         we         = 1'b1;
         wpos       = split_pos;
         wdata.free = 1'b1;
         wdata.size = extra_ff;
      end else if (cmd.merge_wr) begin
         we         = 1'b1;
         wpos       = base_start;
         wdata.free = 1'b1;
         wdata.size = merge_size;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[slot(wpos)] <= wdata;
      end
      rdata_ff <= mem[slot(cur_start_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         zero_ff      <= (req_amount == '0);
         need_ff      <= need_in;
         address_ff   <= req_address;
         cur_start_ff <= '0;
         prev_free_ff <= 1'b0;
         granted_ff   <= '0;
      end
      if (cmd.advance) begin
         prev_start_ff <= cur_start_ff;
         prev_size_ff  <= rdata_ff.size;
         prev_free_ff  <= rdata_ff.free;
         cur_start_ff  <= POS_W'(next_pos);
      end
      if (cmd.hit_latch) begin
         hit_start_ff <= cur_start_ff;
         hit_size_ff  <= rdata_ff.size;
         hit_end_ff   <= stat.at_end;
         cur_start_ff <= POS_W'(next_pos);
      end
      if (cmd.take) begin
         extra_ff   <= extra;
         granted_ff <= payload_pos[ADDR_W-1:0];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_granted_address = granted_ff;

endmodule

// File: hdl/ffba_ctrl.sv
// Controller: sequences header init, the block walk, split, merge and the result strobe.
module ffba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ffba_pkg::stat_type  stat,
   output ffba_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_strobe
);
   import ffba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_DONE;
      busy            = (state_ff != S_IDLE);
      rsp_strobe      = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.is_free && stat.zero_req) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_ZERO;
               state_in        = S_RESP;
            end else if (stat.is_free && stat.null_free) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_DONE;
               state_in        = S_RESP;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_EXAM;
         end
         S_EXAM: begin
            if (!stat.is_free) begin
               if (stat.fit) begin
                  cmd.take        = 1'b1;
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_DONE;
                  state_in        = stat.do_split ? S_SPLIT : S_RESP;
               end else if (stat.at_end) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NO_SPACE;
                  state_in        = S_RESP;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_WAIT;
               end
            end else begin
               if (stat.hit_free) begin
                  cmd.hit_latch = 1'b1;
                  state_in      = S_NWAIT;
               end else if (stat.at_end) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_BAD_FREE;
                  state_in        = S_RESP;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_WAIT;
               end
            end
         end
         S_SPLIT: begin
            cmd.split_wr = 1'b1;
            state_in     = S_RESP;
         end
         S_NWAIT: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            cmd.merge_wr    = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_in        = S_RESP;
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: controller plus datapath.
//
// First-fit allocator over a byte pool cut into contiguous blocks, each led by a
// fixed-size header. Issue a word by raising start while busy is low; the word is
// taken at that clock edge. req_action 0 allocates req_amount bytes (rounded up to
// 8); req_action 1 frees the payload offset on req_address (0 is ignored). Exactly
// one result word follows: rsp_strobe is high for one cycle with rsp_status (0 done,
// 1 no space, 2 zero request, 3 unknown free address) and rsp_granted_address (the
// payload offset, 0 unless an allocate succeeded). The result cannot be held off;
// sample it on the strobe. After reset the block writes the initial whole-pool
// header with busy high. A zero request or a null free goes straight from the
// request check to the strobe; any other word walks the headers in address order,
// with one memory read and one compare per block visited, then the result; a split
// adds the split write and a free adds the read of the right neighbor and the merge
// write. The walk is bounded by the one registered header read per block, so the
// time per word grows with fragmentation. busy drops the cycle after the strobe.
module first_fit_block_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [ffba_pkg::AMOUNT_W-1:0]   req_amount,
   input  logic [ffba_pkg::ADDR_W-1:0]     req_address,
   output logic                            rsp_strobe,
   output logic [ffba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]     rsp_granted_address
);
   import ffba_pkg::*;

   // Command and status bundles between the two halves.
   cmd_type  cmd;
   stat_type stat;

   // Sequence the walk; decide split, merge and the status code.
   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Hold the request, the header memory and the walk pointers.
   ffba_dp u_dp (
      .clock               (clock),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_amount          (req_amount),
      .req_address         (req_address),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

endmodule

// File: dv/first_fit_block_allocator_top_tb.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module first_fit_block_allocator_top_tb;
   import ffba_pkg::*;

   // Most header slots a pool can hold: every block keeps a header plus 8 bytes.
   localparam int MAX_BLOCKS     = POOL_BYTES / (HEADER_BYTES + ALIGN_BYTES) + 1;
   localparam int RANDOM_WORDS   = 450;
   localparam int LIVE_CAP       = 40;
   // The slowest word walks every block; the limit covers that walk several times over.
   localparam int WATCHDOG_LIMIT = 20000;
   // busy drops in the cycle after the strobe; give the tail a little slack.
   localparam int TAIL_CYCLES    = 16;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_action;
   logic [AMOUNT_W-1:0] req_amount;
   logic [ADDR_W-1:0]   req_address;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_granted_address;

   first_fit_block_allocator_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_amount          (req_amount),
      .req_address         (req_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow pool: the block chain in address order, as the allocator
   // should hold it after every accepted word.
   // ------------------------------------------------------------------
   logic [POS_W-1:0] seg_start [MAX_BLOCKS];
   logic [POS_W-1:0] seg_size  [MAX_BLOCKS];
   logic             seg_free  [MAX_BLOCKS];
   int               seg_count;

   // Result words still owed by the block, oldest first.
   logic [STATUS_W-1:0] due_status [$];
   logic [ADDR_W-1:0]   due_grant  [$];

   int mismatch_count;
   int result_count;
   int idle_cycles;
   bit burst_mode;

   logic [STATUS_W-1:0] want_status;
   logic [ADDR_W-1:0]   want_grant;

   // Directed stimulus table. Rows with known set carry a hand-typed answer.
   typedef struct packed {
      logic                act;
      logic [AMOUNT_W-1:0] amount;
      logic [ADDR_W-1:0]   address;
      logic                known;
      status_type          status;
      logic [ADDR_W-1:0]   grant;
   } plan_row_type;

   plan_row_type plan [32];
   int           plan_n;

   function automatic void pool_clear();
      seg_start[0] = '0;
      seg_size[0]  = POS_W'(POOL_BYTES);
      seg_free[0]  = 1'b1;
      seg_count    = 1;
   endfunction

   function automatic void drop_seg(input int idx);
      int j;
      for (j = idx; j + 1 < seg_count; j++) begin
         seg_start[j] = seg_start[j+1];
         seg_size[j]  = seg_size[j+1];
         seg_free[j]  = seg_free[j+1];
      end
      seg_count--;
   endfunction

   // Fold every run of adjacent free blocks into its first block.
   function automatic void merge_free_segs();
      int i;
      i = 0;
      while (i + 1 < seg_count) begin
         if (seg_free[i] && seg_free[i+1]) begin
            seg_size[i] = seg_size[i] + seg_size[i+1];
            drop_seg(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   // Apply one command word to the shadow pool and return the result word it owes.
   function automatic void pool_outcome(input logic act,
                                        input logic [AMOUNT_W-1:0] amt,
                                        input logic [ADDR_W-1:0] adr,
                                        output status_type st,
                                        output logic [ADDR_W-1:0] grant);
      logic [CMP_W-1:0] need;
      logic [CMP_W-1:0] extra;
      logic [HIT_W-1:0] payload;
      int               i;
      int               j;
      bit               found;
      st    = ST_DONE;
      grant = '0;
      found = 1'b0;
      if (act == ACT_ALLOC) begin
         if (amt == '0) begin
            st = ST_ZERO;
         end else begin
            need = ((CMP_W'(amt) + CMP_W'(ALIGN_BYTES - 1)) & ~CMP_W'(ALIGN_BYTES - 1))
                   + CMP_W'(HEADER_BYTES);
            st = ST_NO_SPACE;
            for (i = 0; i < seg_count && !found; i++) begin
               if (seg_free[i] && CMP_W'(seg_size[i]) >= need) begin
                  extra = CMP_W'(seg_size[i]) - need;
                  // Split only when the leftover is larger than a header plus 8 bytes.
                  if (extra > CMP_W'(HEADER_BYTES + ALIGN_BYTES) && seg_count < MAX_BLOCKS) begin
                     for (j = seg_count; j > i + 1; j--) begin
                        seg_start[j] = seg_start[j-1];
                        seg_size[j]  = seg_size[j-1];
                        seg_free[j]  = seg_free[j-1];
                     end
                     seg_start[i+1] = seg_start[i] + POS_W'(need);
                     seg_size[i+1]  = POS_W'(extra);
                     seg_free[i+1]  = 1'b1;
                     seg_count++;
                     seg_size[i] = POS_W'(need);
                  end
                  seg_free[i] = 1'b0;
                  grant = ADDR_W'(seg_start[i] + POS_W'(HEADER_BYTES));
                  st    = ST_DONE;
                  found = 1'b1;
               end
            end
         end
      end else if (adr != '0) begin
         // Only an exact payload offset matches; already-free blocks still merge.
         st = ST_BAD_FREE;
         for (i = 0; i < seg_count && !found; i++) begin
            payload = HIT_W'(seg_start[i]) + HIT_W'(HEADER_BYTES);
            if (payload == HIT_W'(adr)) begin
               seg_free[i] = 1'b1;
               merge_free_segs();
               st    = ST_DONE;
               found = 1'b1;
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on result word %0d: %s got %0d want %0d", result_count, what, got,
               want);
      mismatch_count++;
   endtask

   task automatic add_row(input logic act, input logic [AMOUNT_W-1:0] amt,
                          input logic [ADDR_W-1:0] adr, input logic known,
                          input status_type st, input logic [ADDR_W-1:0] grant);
      plan[plan_n].act     = act;
      plan[plan_n].amount  = amt;
      plan[plan_n].address = adr;
      plan[plan_n].known   = known;
      plan[plan_n].status  = st;
      plan[plan_n].grant   = grant;
      plan_n++;
   endtask

   // Present one command word, hold it until the block takes it, then book the
   // result it owes. Start stays high on exit so a back-to-back word needs no
   // second assignment in the same step.
   task automatic issue_word(input logic act, input logic [AMOUNT_W-1:0] amt,
                             input logic [ADDR_W-1:0] adr, input logic known,
                             input status_type typed_st, input logic [ADDR_W-1:0] typed_grant,
                             output status_type st, output logic [ADDR_W-1:0] grant);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= act;
      req_amount  <= amt;
      req_address <= adr;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Taken at this edge: advance the shadow pool.
      pool_outcome(act, amt, adr, st, grant);
      if (known) begin
         due_status.push_back(typed_st);
         due_grant.push_back(typed_grant);
      end else begin
         due_status.push_back(st);
         due_grant.push_back(grant);
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker and watchdog. Outputs are sampled at the rising edge,
   // before the block's own updates for that edge land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (due_status.size() == 0) begin
               report_mismatch("result word with nothing pending, status",
                               int'(rsp_status), 0);
            end else begin
               want_status = due_status.pop_front();
               want_grant  = due_grant.pop_front();
               if (rsp_status !== want_status)
                  report_mismatch("status", int'(rsp_status), int'(want_status));
               if (rsp_granted_address !== want_grant)
                  report_mismatch("granted address", int'(rsp_granted_address),
                                  int'(want_grant));
            end
            result_count++;
         end
         // Count only cycles in which no word moves on either side.
         if (rsp_strobe || (start && !busy))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [ADDR_W-1:0]   live_addr [LIVE_CAP];
      int                  live_n;
      logic [ADDR_W-1:0]   freed_addr;
      logic                act;
      logic [AMOUNT_W-1:0] amt;
      logic [ADDR_W-1:0]   adr;
      status_type          st;
      logic [ADDR_W-1:0]   grant;
      int                  k;
      int                  n;
      int                  pick;
      int                  idx;

      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_ALLOC;
      req_amount     = '0;
      req_address    = '0;
      mismatch_count = 0;
      result_count   = 0;
      idle_cycles    = 0;
      burst_mode     = 1'b0;
      plan_n         = 0;
      live_n         = 0;
      freed_addr     = '0;
      pool_clear();

      // Fresh pool: one free block spanning everything.
      add_row(ACT_ALLOC, 17'd0,      16'hFFFF, 1'b1, ST_ZERO,     16'd0);
      add_row(ACT_FREE,  17'h1FFFF,  16'd0,    1'b1, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'd1,      16'd0,    1'b1, ST_DONE,     16'd24);
      add_row(ACT_ALLOC, 17'd8,      16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'h1FFFF,  16'd0,    1'b1, ST_NO_SPACE, 16'd0);
      add_row(ACT_ALLOC, 17'd65536,  16'd0,    1'b1, ST_NO_SPACE, 16'd0);
      add_row(ACT_FREE,  17'd0,      16'hFFFF, 1'b1, ST_BAD_FREE, 16'd0);
      add_row(ACT_FREE,  17'd0,      16'd12345, 1'b1, ST_BAD_FREE, 16'd0);
      // Free, free again while still a block of its own, then merge all.
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd56,   1'b0, ST_DONE,     16'd0);
      // Exact fit of the whole pool, then nothing left.
      add_row(ACT_ALLOC, 17'd65512,  16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'd1,      16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      // Leftover of exactly header plus 8: no split.
      add_row(ACT_ALLOC, 17'd65480,  16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      // Leftover one step larger: split, then the small tail taken whole.
      add_row(ACT_ALLOC, 17'd65472,  16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'd8,      16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd65520, 1'b0, ST_DONE,    16'd0);
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      // Three blocks, free the middle, then merge from both sides.
      add_row(ACT_ALLOC, 17'd100,    16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'd200,    16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_ALLOC, 17'd300,    16'd0,    1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd152,  1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd24,   1'b0, ST_DONE,     16'd0);
      add_row(ACT_FREE,  17'd0,      16'd376,  1'b0, ST_DONE,     16'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < plan_n; k++) begin
         issue_word(plan[k].act, plan[k].amount, plan[k].address, plan[k].known,
                    plan[k].status, plan[k].grant, st, grant);
      end

      // Random traffic: mostly small allocations and frees of live blocks, with
      // zero and oversized requests, double frees and stray addresses mixed in.
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 32 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         // Hold off until the block has answered everything owed.
         if (n % 150 == 75) begin
            start <= 1'b0;
            while (due_status.size() != 0) @(posedge clock);
         end

         pick = $urandom_range(0, 99);
         if (live_n >= LIVE_CAP)
            pick = 60;
         if (live_n == 0 && pick >= 50 && pick < 85)
            pick = 20;

         act = ACT_ALLOC;
         amt = AMOUNT_W'($urandom_range(0, 131071));
         adr = ADDR_W'($urandom_range(0, 65535));
         if (pick < 2) begin
            amt = '0;
         end else if (pick < 5) begin
            amt = AMOUNT_W'($urandom_range(1, 131071));
         end else if (pick < 12) begin
            amt = AMOUNT_W'($urandom_range(1, 4096));
         end else if (pick < 50) begin
            amt = AMOUNT_W'($urandom_range(1, 256));
         end else begin
            act = ACT_FREE;
            if (pick < 85) begin
               idx        = $urandom_range(0, live_n - 1);
               adr        = live_addr[idx];
               freed_addr = adr;
               live_addr[idx] = live_addr[live_n-1];
               live_n--;
            end else if (pick < 90) begin
               adr = freed_addr;
            end else if (pick < 95) begin
               adr = ADDR_W'($urandom_range(0, 65535));
            end else if (pick < 98) begin
               // Off an aligned payload offset: never matches.
               adr = (live_n > 0 ? live_addr[0] : freed_addr) + 16'd4;
            end else begin
               adr = '0;
            end
         end

         issue_word(act, amt, adr, 1'b0, ST_DONE, '0, st, grant);
         if (act == ACT_ALLOC && st == ST_DONE && live_n < LIVE_CAP) begin
            live_addr[live_n] = grant;
            live_n++;
         end
      end

      start <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
